### sv/bac_pkg.sv
// Shared types, constants and modular helpers for the banded array counter.
package bac_pkg;

  localparam int COUNT_W = 30;
  localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

  // Per-cycle commands broadcast along the cell chain
  typedef struct packed {
    logic step;   // apply one element to every cell
    logic seed;   // first element of an array
    logic shift;  // move counts one cell towards cell 0
  } bac_ctrl_t;

  // (a + b + c) mod COUNT_MOD, each operand already reduced
  function automatic logic [COUNT_W-1:0] mod_add3(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b,
                                                  input logic [COUNT_W-1:0] c);
    logic [COUNT_W+1:0] s;
    logic [COUNT_W+1:0] p1;
    logic [COUNT_W+1:0] p2;
    p1 = {2'b00, COUNT_MOD};
    p2 = p1 + p1;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    if (s >= p2) begin
      s = s - p2;
    end else if (s >= p1) begin
      s = s - p1;
    end
    return s[COUNT_W-1:0];
  endfunction

  // (a + b) mod COUNT_MOD, each operand already reduced
  function automatic logic [COUNT_W-1:0] mod_add2(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    logic [COUNT_W:0] p1;
    p1 = {1'b0, COUNT_MOD};
    s = {1'b0, a} + {1'b0, b};
    if (s >= p1) begin
      s = s - p1;
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

### sv/bac_cell.sv
// One cell of the count chain: holds the count for a single element value.
module bac_cell import bac_pkg::*; #(
  parameter int EW         = 8,
  parameter int CELL_VALUE = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bac_ctrl_t          ctrl,
  input  logic [EW-1:0]      elem,
  input  logic [EW-1:0]      bound,
  input  logic [COUNT_W-1:0] left,
  input  logic [COUNT_W-1:0] right,
  output logic [COUNT_W-1:0] count
);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               allowed;
  logic [COUNT_W-1:0] right_use;
  logic [COUNT_W-1:0] band_sum;

  always_comb begin
    allowed   = (EW'(CELL_VALUE) <= bound) && ((elem == '0) || (elem == EW'(CELL_VALUE)));
    // upper neighbour only counts while it lies inside the bound
    right_use = (EW'(CELL_VALUE + 1) <= bound) ? right : '0;
    band_sum  = mod_add3(count_r, left, right_use);
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.shift) begin
      count_nxt = right;
    end else if (ctrl.step) begin
      if (!allowed) begin
        count_nxt = '0;
      end else if (ctrl.seed) begin
        count_nxt = COUNT_W'(1);
      end else begin
        count_nxt = band_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

### sv/bac_accum.sv
// Modular accumulator that totals the counts drained out of the chain.
module bac_accum import bac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               add_en,
  input  logic [COUNT_W-1:0] value,
  output logic [COUNT_W-1:0] acc
);

  logic [COUNT_W-1:0] acc_r;
  logic [COUNT_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (add_en) begin
      acc_nxt = mod_add2(acc_r, value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### sv/banded_array_count_dp_unit.sv
// Top level of the banded array counter: cell chain, drain sequencer, output register.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_ready   in_element_value[7:0], in_is_last
//  out      output     out_valid/out_ready out_array_count[29:0]
//  cfg      input      cfg_wr_en           cfg_wr_data[7:0] (max_value)
//
// An element that is not last updates all cells together and leaves in_ready high.
// A last element moves the sequencer into the drain state, where the chain
// shifts its counts into the accumulator, and then into the done state, which
// loads the result; in_ready is low in both the drain and the done state.
// The drain shifts zeros in behind it, so the chain is clear for the next array.
// Synchronous reset clears all counts and sets max_value to 128.
// A result held by out_ready low stalls the load of the next result, and the input with it.
module banded_array_count_dp_unit import bac_pkg::*; #(
  parameter int MAX_VALUE_LIMIT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_element_value,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] out_array_count,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int N   = MAX_VALUE_LIMIT;
  localparam int VW  = $clog2(N + 2);
  localparam int EW  = (VW > 8) ? VW : 8;
  localparam int CW  = $clog2(N);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               start_r, start_nxt;
  logic [7:0]         max_value_r, max_value_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_data_r, out_data_nxt;

  logic               in_fire;
  logic               out_free;
  logic [EW-1:0]      cfg_ext;
  logic [EW-1:0]      bound;
  logic [EW-1:0]      elem;
  bac_ctrl_t          ctrl;
  logic [COUNT_W-1:0] counts [N];
  logic [COUNT_W-1:0] acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cfg_ext = EW'(max_value_r);
  assign bound   = (cfg_ext > EW'(N)) ? EW'(N) : cfg_ext;
  assign elem    = EW'(in_element_value);

  always_comb begin
    ctrl.step  = in_fire;
    ctrl.seed  = start_r;
    ctrl.shift = (state_r == ST_DRAIN);
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic [COUNT_W-1:0] left_in;
      logic [COUNT_W-1:0] right_in;
      if (gi == 0) begin : g_lo
        assign left_in = '0;
      end else begin : g_lo
        assign left_in = counts[gi-1];
      end
      if (gi == N - 1) begin : g_hi
        assign right_in = '0;
      end else begin : g_hi
        assign right_in = counts[gi+1];
      end
      bac_cell #(
        .EW         (EW),
        .CELL_VALUE (gi + 1)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .elem  (elem),
        .bound (bound),
        .left  (left_in),
        .right (right_in),
        .count (counts[gi])
      );
    end
  endgenerate

  bac_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (in_fire),
    .add_en (state_r == ST_DRAIN),
    .value  (counts[0]),
    .acc    (acc)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    max_value_nxt = max_value_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      max_value_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          start_nxt = in_is_last;
          if (in_is_last) begin
            state_nxt = ST_DRAIN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(N - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      start_r     <= 1'b1;
      max_value_r <= 8'd128;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      max_value_r <= max_value_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_array_count = out_data_r;

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_last) |=> (state_r == ST_DRAIN))
    else $error("last element did not start the drain");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && cnt_r == CW'(N - 1)) |=> (state_r == ST_DONE))
    else $error("drain did not end after one pass of the chain");

  a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (counts[0] == '0 && counts[N-1] == '0))
    else $error("chain not clear after drain");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the done state");

endmodule

### tb/tb_banded_array_count_dp_unit.sv
// Self-checking testbench for the banded array counter, with its own count predictor.
`timescale 1ns / 1ps

module tb_banded_array_count_dp_unit;
  import bac_pkg::*;

  localparam int MAXV = 128;
  localparam int DRAIN_CYCLES = MAXV + 12;
  localparam int STALL_LIMIT = 5000;

  typedef logic [7:0] elem_q_t[$];

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_element_value;
  logic               in_is_last;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] out_array_count;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;

  // predictor state
  logic [COUNT_W-1:0] prefix_counts [MAXV];
  bit                 array_fresh;
  logic [7:0]         bound_reg;

  logic [COUNT_W-1:0] pending_counts[$];
  int                 mismatches;
  int                 snd_idle_pct;
  int                 rcv_stall_pct;
  int                 hold_len;
  int                 hold_seq;
  int                 hold_seen;
  int                 hold_left;
  int                 quiet_cycles;

  banded_array_count_dp_unit #(.MAX_VALUE_LIMIT(MAXV)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_value(in_element_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_array_count (out_array_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one element to the predicted counts; returns 1 with the total on a last element.
  function automatic bit advance_counts(input logic [7:0] elem, input bit last,
                                        output logic [COUNT_W-1:0] total);
    logic [COUNT_W-1:0] nxt [MAXV];
    longint unsigned acc;
    int m;
    m = (bound_reg > MAXV) ? MAXV : int'(bound_reg);
    for (int i = 0; i < MAXV; i++) begin
      acc = 0;
      if (i + 1 <= m && (elem == 0 || int'(elem) == i + 1)) begin
        if (array_fresh) begin
          acc = 1;
        end else begin
          acc = prefix_counts[i];
          if (i > 0) acc += prefix_counts[i-1];
          // neighbour above the bound counts as zero
          if (i + 2 <= m && i + 1 < MAXV) acc += prefix_counts[i+1];
          acc = acc % COUNT_MOD;
        end
      end
      nxt[i] = acc[COUNT_W-1:0];
    end
    prefix_counts = nxt;
    total = '0;
    if (!last) begin
      array_fresh = 1'b0;
      return 1'b0;
    end
    acc = 0;
    for (int i = 0; i < MAXV; i++) acc = (acc + prefix_counts[i]) % COUNT_MOD;
    total = acc[COUNT_W-1:0];
    foreach (prefix_counts[i]) prefix_counts[i] = '0;
    array_fresh = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_element(input logic [7:0] value, input bit last);
    logic [COUNT_W-1:0] total;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= value;
    in_is_last       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (advance_counts(value, last, total)) pending_counts.push_back(total);
  endtask

  task automatic send_array(input elem_q_t vals);
    foreach (vals[k]) send_element(vals[k], k == vals.size() - 1);
  endtask

  // Sender idles until every result is back, then lets the drain finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(input logic [7:0] bound);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bound;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bound_reg = bound;
  endtask

  task automatic send_random_arrays(input int n_items, input logic [7:0] bound);
    int sent;
    int len;
    int eff;
    int walk;
    int pick;
    logic [7:0] value;
    settle_block();
    write_bound(bound);
    eff = (bound > MAXV) ? MAXV : int'(bound);
    if (eff < 1) eff = 1;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(30, 9);
      else len = $urandom_range(80, 31);
      walk = $urandom_range(eff, 1);
      for (int k = 0; k < len; k++) begin
        // fixed values walk by at most one per position so arrays stay countable
        walk += int'($urandom_range(2)) - 1;
        if (walk < 1) walk = 1;
        if (walk > eff) walk = eff;
        pick = $urandom_range(99);
        if (pick < 55) value = 8'd0;
        else if (pick < 88) value = walk[7:0];
        else value = 8'($urandom_range(255));
        send_element(value, k == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_single_element_arrays();
    send_array('{8'd0});
    send_array('{8'd1});
    send_array('{8'd128});
    send_array('{8'd129});
    send_array('{8'd255});
  endtask

  task automatic test_short_arrays();
    send_array('{8'd0, 8'd0});
    send_array('{8'd1, 8'd0});
    send_array('{8'd128, 8'd0});
    send_array('{8'd5, 8'd0, 8'd7});
    send_array('{8'd5, 8'd0, 8'd8});
  endtask

  task automatic test_bound_extremes();
    settle_block();
    write_bound(8'd0);
    send_array('{8'd0});
    send_array('{8'd1});
    settle_block();
    write_bound(8'd1);
    send_array('{8'd0, 8'd0, 8'd0});
    settle_block();
    write_bound(8'd255);
    send_array('{8'd0, 8'd0});
    settle_block();
    write_bound(8'd2);
    send_array('{8'd0, 8'd3});
  endtask

  task automatic test_bound_change_mid_array();
    settle_block();
    write_bound(8'd128);
    send_element(8'd0, 1'b0);
    send_element(8'd0, 1'b0);
    settle_block();
    write_bound(8'd3);
    send_element(8'd0, 1'b1);
    settle_block();
    write_bound(8'd128);
    send_element(8'd5, 1'b0);
    settle_block();
    write_bound(8'd3);
    send_element(8'd0, 1'b1);
  endtask

  // Receiver holds off while short arrays keep coming, so the input backs up.
  task automatic test_output_backpressure();
    settle_block();
    write_bound(8'd128);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_len = 800;
    hold_seq++;
    repeat (20) send_array('{8'd0, 8'($urandom_range(128))});
    settle_block();
  endtask

  task automatic test_random_no_idle();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_random_arrays(250, 8'd128);
    send_random_arrays(80, 8'($urandom_range(127, 4)));
  endtask

  task automatic test_random_sender_idle();
    snd_idle_pct  = 78;
    rcv_stall_pct = 0;
    send_random_arrays(250, 8'd128);
    send_random_arrays(80, 8'd2);
  endtask

  task automatic test_random_receiver_stall();
    snd_idle_pct  = 0;
    rcv_stall_pct = 78;
    send_random_arrays(250, 8'd255);
    send_random_arrays(80, 8'($urandom_range(255, 1)));
  endtask

  task automatic test_random_both_idle();
    snd_idle_pct  = 34;
    rcv_stall_pct = 34;
    send_random_arrays(250, 8'd128);
    send_random_arrays(80, 8'd1);
  endtask

  always @(posedge clk) begin : check_results
    logic [COUNT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual array_count %0d",
                 $time, out_array_count);
        mismatches++;
      end else begin
        want = pending_counts.pop_front();
        if (out_array_count !== want) begin
          $display("%0t: array_count mismatch, expected %0d, actual %0d",
                   $time, want, out_array_count);
          mismatches++;
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_element_value <= 8'd0;
    in_is_last       <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= 8'd0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_len      = 0;
    hold_seq      = 0;
    foreach (prefix_counts[i]) prefix_counts[i] = '0;
    array_fresh = 1'b1;
    bound_reg   = 8'd128;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_element_arrays();
    test_short_arrays();
    test_bound_extremes();
    test_bound_change_mid_array();
    test_output_backpressure();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    settle_block();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
